// File: rtl/core/cmt_pkg.sv
// cmt_pkg: shared types and constants for the capability mask table
// holds table size, operation codes and the controller-to-datapath command struct
// no dependencies
package cmt_pkg;

	localparam int ENTRIES = 256;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ID_W = 16;
	localparam int MASK_W = 64;
	localparam int OP_W = 3;
	localparam logic [ID_W-1:0] ENTRIES_ID = ID_W'(ENTRIES);

	typedef enum logic [OP_W-1:0] {
		OP_READ    = 3'd0,
		OP_SET     = 3'd1,
		OP_TEST    = 3'd2,
		OP_DROP    = 3'd3,
		OP_GRANT   = 3'd4,
		OP_INHERIT = 3'd5,
		OP_CLEAR   = 3'd6
	} op_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

endpackage

// File: rtl/core/cmt_ctrl.sv
// cmt_ctrl: sequencing state machine for the capability mask table
// issues capture and commit commands, owns both handshakes
// depends on cmt_pkg
module cmt_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  logic         out_stall,
	output cmt_pkg::cmd_t cmd
);
	import cmt_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.capture = in_valid && (state_q == ST_IDLE);
	// result slot is free when empty or being taken this cycle
	assign cmd.commit = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.commit))
		else $error("capture and commit in the same cycle");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("committed word not presented");

	a_capture_execs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_EXEC) && in_stall)
		else $error("captured word not executing");

endmodule

// File: rtl/core/cmt_datapath.sv
// cmt_datapath: mask tables, read-modify-write logic and result registers
// tables are read on capture and written back on commit
// depends on cmt_pkg
module cmt_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmt_pkg::cmd_t              cmd,
	input  logic [cmt_pkg::OP_W-1:0]   operation,
	input  logic [cmt_pkg::ID_W-1:0]   target_id,
	input  logic [cmt_pkg::ID_W-1:0]   source_id,
	input  logic [cmt_pkg::MASK_W-1:0] mask_value,
	output logic                       status,
	output logic                       has_all,
	output logic [cmt_pkg::MASK_W-1:0] effective_out
);
	import cmt_pkg::*;

	logic [MASK_W-1:0] eff_mem [ENTRIES];
	logic [MASK_W-1:0] perm_mem [ENTRIES];
	logic [MASK_W-1:0] inh_mem [ENTRIES];
	// entry written since reset; unwritten entries read as their reset value
	logic [ENTRIES-1:0] valid_q;

	op_t               op_s1;
	logic [IDX_W-1:0]  tgt_s1;
	logic [IDX_W-1:0]  raddr_s1;
	logic [MASK_W-1:0] mask_s1;
	logic              tgt_ok_s1;
	logic              src_ok_s1;
	logic              rd_vld_s1;
	logic [MASK_W-1:0] rd_eff_s1;
	logic [MASK_W-1:0] rd_perm_s1;
	logic [MASK_W-1:0] rd_inh_s1;

	logic              status_q;
	logic              has_all_q;
	logic [MASK_W-1:0] eff_out_q;

	op_t               in_op;
	logic [IDX_W-1:0]  raddr;
	logic [MASK_W-1:0] rst_val;
	logic [MASK_W-1:0] cur_eff;
	logic [MASK_W-1:0] cur_perm;
	logic [MASK_W-1:0] cur_inh;
	logic [MASK_W-1:0] new_eff;
	logic [MASK_W-1:0] new_perm;
	logic [MASK_W-1:0] new_inh;
	logic              wr_req;
	logic              wr_en;
	logic              res_status;
	logic              res_has_all;
	logic [MASK_W-1:0] res_eff;

	assign in_op = op_t'(operation);
	// inherit reads the parent entry, every other operation the target
	assign raddr = (in_op == OP_INHERIT) ? source_id[IDX_W-1:0] : target_id[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1 <= in_op;
			tgt_s1 <= target_id[IDX_W-1:0];
			raddr_s1 <= raddr;
			mask_s1 <= mask_value;
			tgt_ok_s1 <= (target_id < ENTRIES_ID);
			src_ok_s1 <= (source_id < ENTRIES_ID);
			rd_eff_s1 <= eff_mem[raddr];
			rd_perm_s1 <= perm_mem[raddr];
			rd_inh_s1 <= inh_mem[raddr];
			rd_vld_s1 <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			eff_mem[tgt_s1] <= new_eff;
			perm_mem[tgt_s1] <= new_perm;
			inh_mem[tgt_s1] <= new_inh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[tgt_s1] <= 1'b1;
		end
	end

	assign rst_val = ((raddr_s1 >> 1) == '0) ? '1 : '0;
	assign cur_eff = rd_vld_s1 ? rd_eff_s1 : rst_val;
	assign cur_perm = rd_vld_s1 ? rd_perm_s1 : rst_val;
	assign cur_inh = rd_vld_s1 ? rd_inh_s1 : rst_val;

	always_comb begin
		new_eff = cur_eff;
		new_perm = cur_perm;
		new_inh = cur_inh;
		wr_req = 1'b0;
		res_status = !tgt_ok_s1;
		res_has_all = 1'b0;
		res_eff = '0;
		case (op_s1)
			OP_READ: begin
				res_eff = tgt_ok_s1 ? cur_eff : '0;
			end
			OP_SET: begin
				new_eff = mask_s1 & cur_perm;
				wr_req = tgt_ok_s1;
			end
			OP_TEST: begin
				res_has_all = tgt_ok_s1 && ((cur_eff & mask_s1) == mask_s1);
			end
			OP_DROP: begin
				new_eff = cur_eff & ~mask_s1;
				new_perm = cur_perm & ~mask_s1;
				wr_req = tgt_ok_s1;
			end
			OP_GRANT: begin
				new_eff = cur_eff | mask_s1;
				new_perm = cur_perm | mask_s1;
				wr_req = tgt_ok_s1;
			end
			OP_INHERIT: begin
				new_eff = cur_inh;
				new_perm = cur_inh;
				new_inh = cur_inh;
				wr_req = tgt_ok_s1 && src_ok_s1;
				res_status = !(tgt_ok_s1 && src_ok_s1);
			end
			OP_CLEAR: begin
				new_eff = '0;
				new_perm = '0;
				new_inh = '0;
				wr_req = tgt_ok_s1;
			end
			default: begin
				// unused code: no change, all-zero result
				res_status = 1'b0;
			end
		endcase
	end

	assign wr_en = cmd.commit && wr_req;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= res_status;
			has_all_q <= res_has_all;
			eff_out_q <= res_eff;
		end
	end

	assign status = status_q;
	assign has_all = has_all_q;
	assign effective_out = eff_out_q;

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> tgt_ok_s1 && !res_status)
		else $error("table write with out of range id");

	a_no_write_on_query: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (op_s1 != OP_READ) && (op_s1 != OP_TEST))
		else $error("read or test wrote the table");

	a_written_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[$past(tgt_s1)])
		else $error("written entry not marked valid");

endmodule

// File: rtl/core/capability_mask_table_top.sv
// capability_mask_table_top: result word is registered on commit, which follows the accept
// once the output is free; each word is read from the mask tables on accept and written back
// on commit, and no new word is accepted before its commit; a waiting result does not block the next
// accept, but a held result holds the executing word and with it the input
// reset: entries 0 and 1 read all ones, all others zero, through per-entry
// valid bits cleared at once; no clearing pass, the block accepts right away
module capability_mask_table_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [cmt_pkg::OP_W-1:0]   operation,
	input  logic [cmt_pkg::ID_W-1:0]   target_id,
	input  logic [cmt_pkg::ID_W-1:0]   source_id,
	input  logic [cmt_pkg::MASK_W-1:0] mask_value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       status,
	output logic                       has_all,
	output logic [cmt_pkg::MASK_W-1:0] effective_out
);
	import cmt_pkg::*;

	cmd_t cmd;

	cmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	cmt_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.operation     (operation),
		.target_id     (target_id),
		.source_id     (source_id),
		.mask_value    (mask_value),
		.status        (status),
		.has_all       (has_all),
		.effective_out (effective_out)
	);

endmodule

// File: sim/capability_mask_table_top_tb.sv
// capability_mask_table_top_tb: self-checking bench for the capability mask table
// drives op words through a queue-fed driver, predicts each result word from a local
// copy of the three mask tables and checks every result in order; depends on cmt_pkg
module capability_mask_table_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cmt_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
	localparam logic [MASK_W-1:0] ALL_ONES = {MASK_W{1'b1}};
	localparam int RANDOM_PER_PHASE = 600;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ID_W-1:0]   target;
		logic [ID_W-1:0]   source;
		logic [MASK_W-1:0] mask;
	} cap_word_t;

	typedef struct packed {
		logic              status;
		logic              has_all;
		logic [MASK_W-1:0] eff;
	} cap_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [OP_W-1:0]   operation = '0;
	logic [ID_W-1:0]   target_id = '0;
	logic [ID_W-1:0]   source_id = '0;
	logic [MASK_W-1:0] mask_value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              status;
	logic              has_all;
	logic [MASK_W-1:0] effective_out;

	// local copy of the mask tables, advanced once per accepted word
	logic [MASK_W-1:0] eff_tbl [ENTRIES];
	logic [MASK_W-1:0] perm_tbl [ENTRIES];
	logic [MASK_W-1:0] inh_tbl [ENTRIES];

	cap_word_t   word_q [$];
	cap_result_t result_q [$];
	cap_word_t   cur_word;
	cap_result_t want;

	int send_idle_pct = 23;
	int recv_idle_pct = 67;
	int words_accepted = 0;
	int hold_at = 32'h7fffffff;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int err_cnt = 0;

	capability_mask_table_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.target_id     (target_id),
		.source_id     (source_id),
		.mask_value    (mask_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.has_all       (has_all),
		.effective_out (effective_out)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic cap_result_t apply_cap_op(cap_word_t w);
		cap_result_t r;
		logic tgt_ok;
		logic src_ok;
		logic [IDX_W-1:0] t;
		logic [IDX_W-1:0] s;
		logic [MASK_W-1:0] inh;
		r = '0;
		tgt_ok = (w.target < ENTRIES_ID);
		src_ok = (w.source < ENTRIES_ID);
		t = w.target[IDX_W-1:0];
		s = w.source[IDX_W-1:0];
		case (w.op)
			OP_READ: begin
				if (tgt_ok) r.eff = eff_tbl[t];
				else r.status = 1'b1;
			end
			OP_SET: begin
				if (tgt_ok) eff_tbl[t] = w.mask & perm_tbl[t];
				else r.status = 1'b1;
			end
			OP_TEST: begin
				if (tgt_ok) r.has_all = ((eff_tbl[t] & w.mask) == w.mask);
				else r.status = 1'b1;
			end
			OP_DROP: begin
				if (tgt_ok) begin
					eff_tbl[t] = eff_tbl[t] & ~w.mask;
					perm_tbl[t] = perm_tbl[t] & ~w.mask;
				end else begin
					r.status = 1'b1;
				end
			end
			OP_GRANT: begin
				if (tgt_ok) begin
					eff_tbl[t] = eff_tbl[t] | w.mask;
					perm_tbl[t] = perm_tbl[t] | w.mask;
				end else begin
					r.status = 1'b1;
				end
			end
			OP_INHERIT: begin
				// read the parent first so a self-inherit sees its old value
				if (tgt_ok && src_ok) begin
					inh = inh_tbl[s];
					eff_tbl[t] = inh;
					perm_tbl[t] = inh;
					inh_tbl[t] = inh;
				end else begin
					r.status = 1'b1;
				end
			end
			OP_CLEAR: begin
				if (tgt_ok) begin
					eff_tbl[t] = '0;
					perm_tbl[t] = '0;
					inh_tbl[t] = '0;
				end else begin
					r.status = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// mostly a small working set so operations pile up on the same entries
	function automatic logic [ID_W-1:0] pick_id();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60) return ID_W'($urandom_range(7));
		if (r < 80) return ID_W'($urandom_range(ENTRIES - 1));
		if (r < 90) return ID_W'(ENTRIES + $urandom_range(3));
		return ID_W'($urandom_range(16'hffff));
	endfunction

	function automatic logic [MASK_W-1:0] pick_mask();
		case ($urandom_range(5))
			0: return '0;
			1: return ALL_ONES;
			2: return MASK_W'(1) << $urandom_range(MASK_W - 1);
			3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic cap_word_t rand_word();
		cap_word_t w;
		w.op = OP_W'($urandom_range(7));
		w.target = pick_id();
		// source matters only for inherit; elsewhere it is noise
		w.source = (w.op == OP_INHERIT) ? pick_id() : ID_W'($urandom_range(16'hffff));
		w.mask = pick_mask();
		return w;
	endfunction

	task automatic push_word(logic [OP_W-1:0] op, int tgt, int src, logic [MASK_W-1:0] mask);
		word_q.push_back('{op: op, target: ID_W'(tgt), source: ID_W'(src), mask: mask});
	endtask

	task automatic drain();
		while (word_q.size() != 0 || in_valid || result_q.size() != 0)
			@(negedge clk);
	endtask

	// driver: one op word on the pins, held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= '0;
			target_id <= '0;
			source_id <= '0;
			mask_value <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				result_q.push_back(apply_cap_op(cur_word));
				words_accepted <= words_accepted + 1;
			end
			if (!in_valid || !in_stall) begin
				if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_word = word_q.pop_front();
					in_valid <= 1'b1;
					operation <= cur_word.op;
					target_id <= cur_word.target;
					source_id <= cur_word.source;
					mask_value <= cur_word.mask;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && words_accepted >= hold_at) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor: check each result word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$error("result word with no prediction waiting");
					err_cnt++;
				end else begin
					want = result_q.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						err_cnt++;
					end
					if (has_all !== want.has_all) begin
						$error("has_all: expected %0d, got %0d", want.has_all, has_all);
						err_cnt++;
					end
					if (effective_out !== want.eff) begin
						$error("effective_out: expected %h, got %h", want.eff, effective_out);
						err_cnt++;
					end
				end
			end
			out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
		end
	end

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			eff_tbl[IDX_W'(i)] = (i < 2) ? ALL_ONES : '0;
			perm_tbl[IDX_W'(i)] = (i < 2) ? ALL_ONES : '0;
			inh_tbl[IDX_W'(i)] = (i < 2) ? ALL_ONES : '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset contents, range edges, every op, self-inherit, unused code
		push_word(OP_READ, 0, 0, '0);
		push_word(OP_READ, 1, 16'hffff, ALL_ONES);
		push_word(OP_READ, 2, 0, '0);
		push_word(OP_READ, ENTRIES - 1, 0, '0);
		push_word(OP_READ, ENTRIES, 0, '0);
		push_word(OP_READ, 16'hffff, 0, '0);
		push_word(OP_SET, 2, 0, ALL_ONES);
		push_word(OP_GRANT, 2, 0, 64'hf0f0_0000_ffff_0001);
		push_word(OP_SET, 2, 0, 64'h8000_0000_0000_ffff);
		push_word(OP_TEST, 2, 0, 64'h0000_0000_0000_ff01);
		push_word(OP_TEST, 2, 0, 64'h8000_0000_0000_0001);
		push_word(OP_TEST, 2, 0, '0);
		push_word(OP_TEST, ENTRIES, 0, '0);
		push_word(OP_DROP, 1, 0, 64'h0000_0000_0000_00ff);
		push_word(OP_INHERIT, 3, 1, '0);
		push_word(OP_READ, 3, 0, '0);
		push_word(OP_INHERIT, 3, 3, '0);
		push_word(OP_INHERIT, 4, ENTRIES, '0);
		push_word(OP_INHERIT, 16'hffff, 0, '0);
		push_word(OP_CLEAR, 0, 0, '0);
		push_word(OP_TEST, 0, 0, 64'h1);
		push_word(OP_UNUSED, 5, 5, ALL_ONES);
		push_word(OP_GRANT, ENTRIES - 1, 0, ALL_ONES);
		push_word(OP_DROP, ENTRIES, 0, ALL_ONES);
		push_word(OP_READ, ENTRIES - 1, 0, '0);
		repeat (RANDOM_PER_PHASE) word_q.push_back(rand_word());
		drain();

		send_idle_pct = 67;
		recv_idle_pct = 23;
		repeat (RANDOM_PER_PHASE) word_q.push_back(rand_word());
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_at = words_accepted + 100;
		repeat (RANDOM_PER_PHASE) word_q.push_back(rand_word());
		drain();

		repeat (10) @(negedge clk);
		if (err_cnt == 0 && result_q.size() == 0) begin
			$display("capability_mask_table_top_tb: done, clean");
		end else begin
			$display("capability_mask_table_top_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("capability_mask_table_top_tb: done, errors");
		$finish;
	end

endmodule
